FILE: src/pasc_pkg.sv
// Package: shared constants, register indexes, request modes and control structs.
package pasc_pkg;

   localparam int SAMPLE_BITS_DEFAULT = 24;

   localparam int FACTOR_W   = 17;
   localparam int STRENGTH_W = 17;
   localparam int THRESH_W   = 14;
   localparam int COEFF_W    = 16;
   localparam int CSR_DATA_W = 17;
   localparam int CSR_INDEX_W = 2;
   localparam int MODE_W     = 2;
   localparam int QUOT_W     = 16;
   localparam int MUL_B_W    = 18;

   localparam logic [MODE_W-1:0] MODE_ANALYZE   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_BLOCK_END = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PROCESS   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_UNUSED    = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STRENGTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SMOOTH    = 2'd3;

   localparam logic                  ENABLE_RESET    = 1'b1;
   localparam logic [STRENGTH_W-1:0] STRENGTH_RESET  = 17'd65536;
   localparam logic [THRESH_W-1:0]   THRESHOLD_RESET = 14'd4506;
   localparam logic [COEFF_W-1:0]    SMOOTH_RESET    = 16'd58982;

   localparam logic [FACTOR_W-1:0] UNITY16     = 17'd65536;
   localparam logic [FACTOR_W-1:0] FACTOR_MIN  = 17'd656;
   localparam logic [14:0]         RATIO_SAT   = 15'd16384;
   localparam logic [14:0]         RATIO_ONE   = 15'd4096;
   localparam logic [13:0]         TARGET_KNEE = 14'd5120;
   // ceil(2^17 / 5), exact floor(4d/5) for 4d < 20480
   localparam logic [MUL_B_W-1:0]  RECIP5      = 18'd26215;
   localparam logic [MUL_B_W-1:0]  THREE_UNITY = 18'd196608;

   typedef struct packed {
      logic load;
      logic step;
   } div_ctrl_type;

   typedef struct packed {
      logic [QUOT_W-1:0] quot;
      logic              last;
   } div_stat_type;

endpackage

FILE: src/pasc_if.sv
// Interfaces: request and response channels with valid/ready handshake.
interface pasc_req_if #(
   parameter int SAMPLE_BITS = pasc_pkg::SAMPLE_BITS_DEFAULT
);
   logic                              valid;
   logic                              ready;
   logic [pasc_pkg::MODE_W-1:0]       mode;
   logic signed [SAMPLE_BITS-1:0]     sample_in;

   modport source (output valid, output mode, output sample_in, input ready);
   modport sink   (input valid, input mode, input sample_in, output ready);
endinterface

interface pasc_rsp_if #(
   parameter int SAMPLE_BITS = pasc_pkg::SAMPLE_BITS_DEFAULT
);
   logic                              valid;
   logic                              ready;
   logic signed [SAMPLE_BITS-1:0]     sample_out;
   logic [pasc_pkg::FACTOR_W-1:0]     factor_out;

   modport source (output valid, output sample_out, output factor_out, input ready);
   modport sink   (input valid, input sample_out, input factor_out, output ready);
endinterface

FILE: src/pasc_mul_unit.sv
// Shared multiplier with registered product.
module pasc_mul_unit #(
   parameter int A_W = pasc_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               en,
   input  logic [A_W-1:0]                     a,
   input  logic [pasc_pkg::MUL_B_W-1:0]       b,
   output logic [A_W+pasc_pkg::MUL_B_W-1:0]   prod
);

   logic [A_W+pasc_pkg::MUL_B_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= (A_W+pasc_pkg::MUL_B_W)'(a) * (A_W+pasc_pkg::MUL_B_W)'(b);
      end
   end

   assign prod = prod_ff;

endmodule

FILE: src/pasc_div_unit.sv
// Restoring divider: one compare/subtract step per cycle while ctrl.step is set, 16 quotient bits.
module pasc_div_unit #(
   parameter int SAMPLE_BITS = pasc_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pasc_pkg::div_ctrl_type        ctrl,
   input  logic [SAMPLE_BITS+14:0]       dividend,
   input  logic [SAMPLE_BITS-1:0]        divisor,
   output pasc_pkg::div_stat_type        stat
);

   localparam int RW = SAMPLE_BITS + 15;

   logic [RW-1:0]                 rem_ff, rem_in;
   logic [SAMPLE_BITS-1:0]        dvs_ff, dvs_in;
   logic [pasc_pkg::QUOT_W-1:0]   quot_ff, quot_in;
   logic [3:0]                    k_ff, k_in;
   logic [RW-1:0]                 cand;

   always_comb begin
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quot_in = quot_ff;
      k_in    = k_ff;
      cand    = RW'(dvs_ff) << k_ff;
      if (ctrl.load) begin
         rem_in  = dividend;
         dvs_in  = divisor;
         quot_in = '0;
         k_in    = 4'd15;
      end else if (ctrl.step) begin
         if (rem_ff >= cand) begin
            rem_in        = rem_ff - cand;
            quot_in[k_ff] = 1'b1;
         end
         k_in = k_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= '0;
      end else begin
         k_ff <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      quot_ff <= quot_in;
   end

   assign stat.quot = quot_ff;
   assign stat.last = (k_ff == 4'd0);

endmodule

FILE: src/peak_asymmetry_soft_corrector.sv
// Top level: peak tracking, block-end ratio and factor smoothing, soft gain reduction.
//
//   channel  dir  handshake          payload
//   req_ch   in   valid/ready        mode, sample_in
//   rsp_ch   out  valid/ready        sample_out, factor_out
//   csr_*    in   csr_we             csr_index, csr_wdata
//
// Block-end request: 16 divider steps, then 3 multiplier passes and a blend step.
// Process request at or above the knee: 5 passes of the shared multiplier.
// Other requests: straight to ST_DONE. One request at a time; req_ch.ready only when idle.
// A finished result waits in the output register while the next request is taken.
// Reset is synchronous; it restores the CSR registers and clears peaks and factor.
module peak_asymmetry_soft_corrector #(
   parameter int SAMPLE_BITS = pasc_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   pasc_req_if.sink                             req_ch,
   pasc_rsp_if.source                           rsp_ch,
   input  logic                                 csr_we,
   input  logic [pasc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pasc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int SB   = SAMPLE_BITS;
   localparam int FRAC = SB - 2;
   localparam int MA   = (SB > 17) ? SB : 17;
   localparam int PW   = MA + pasc_pkg::MUL_B_W;
   localparam int RW   = SB + 15;
   localparam longint ONE_L  = longint'(1) << FRAC;
   localparam longint EPS_L  = (ONE_L + 999999) / 1000000;
   localparam longint KNEE_L = (9 * ONE_L + 9) / 10;
   localparam logic [SB-1:0] EPS_Q  = SB'(EPS_L);
   localparam logic [SB-1:0] KNEE_Q = SB'(KNEE_L);
   localparam logic [SB+3:0] NINE_ONE = (SB+4)'(9 * ONE_L);
   localparam logic [SB:0]   HALF_Q = (SB+1)'((longint'(1) << (SB - 1)) - 1);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_DIV   = 4'd1;
   localparam logic [3:0] ST_TGT   = 4'd2;
   localparam logic [3:0] ST_FC    = 4'd3;
   localparam logic [3:0] ST_TC    = 4'd4;
   localparam logic [3:0] ST_BLEND = 4'd5;
   localparam logic [3:0] ST_PCALC = 4'd6;
   localparam logic [3:0] ST_P2    = 4'd7;
   localparam logic [3:0] ST_CURVE = 4'd8;
   localparam logic [3:0] ST_CORR  = 4'd9;
   localparam logic [3:0] ST_GAIN  = 4'd10;
   localparam logic [3:0] ST_SCALE = 4'd11;
   localparam logic [3:0] ST_ROUND = 4'd12;
   localparam logic [3:0] ST_DONE  = 4'd13;

   logic [3:0]                          state_ff, state_in;
   logic                                enable_ff, enable_in;
   logic [pasc_pkg::STRENGTH_W-1:0]     strength_ff, strength_in;
   logic [pasc_pkg::THRESH_W-1:0]       thresh_ff, thresh_in;
   logic [pasc_pkg::COEFF_W-1:0]        coeff_ff, coeff_in;
   logic [SB-2:0]                       pos_ff, pos_in;
   logic [SB-1:0]                       neg_ff, neg_in;
   logic [pasc_pkg::FACTOR_W-1:0]       factor_ff, factor_in;
   logic                                rsp_valid_ff, rsp_valid_in;

   logic [SB-1:0]                       res_ff, res_in;
   logic [SB-1:0]                       mag_ff, mag_in;
   logic                                sneg_ff, sneg_in;
   logic [16:0]                         p_ff, p_in;
   logic [16:0]                         target_ff, target_in;
   logic [32:0]                         hold_ff, hold_in;
   logic [SB-1:0]                       rsp_sample_ff, rsp_sample_in;
   logic [pasc_pkg::FACTOR_W-1:0]       rsp_factor_ff, rsp_factor_in;

   logic                                accept, out_free;
   logic [SB-1:0]                       s_raw, s_mag;
   logic                                s_neg;
   logic [SB-2:0]                       pos_new;
   logic [SB-1:0]                       neg_new, hi, lo, lo_f;
   logic                                pos_big;

   pasc_pkg::div_ctrl_type              div_ctrl;
   pasc_pkg::div_stat_type              div_stat;
   logic [RW-1:0]                       div_dividend;

   logic                                mul_en;
   logic [MA-1:0]                       mul_a;
   logic [pasc_pkg::MUL_B_W-1:0]        mul_b;
   logic [PW-1:0]                       prod;
   logic [16:0]                         prod_hi;

   logic [14:0]                         ratio;
   logic [13:0]                         d;
   logic                                gate;
   logic [16:0]                         str_c;
   logic [SB+3:0]                       pdiff;
   logic [SB+19:0]                      pscaled;
   logic [33:0]                         blend_sum;
   logic [PW-1:0]                       rounded;
   logic [SB:0]                         m_raw, m_c, m_neg;

   pasc_div_unit #(.SAMPLE_BITS(SB)) u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (div_dividend),
      .divisor  (lo_f),
      .stat     (div_stat)
   );

   pasc_mul_unit #(.A_W(MA)) u_mul (
      .clock (clock),
      .en    (mul_en),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   assign req_ch.ready      = (state_ff == ST_IDLE);
   assign accept            = req_ch.valid && (state_ff == ST_IDLE);
   assign out_free          = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.sample_out = rsp_sample_ff;
   assign rsp_ch.factor_out = rsp_factor_ff;

   // peak tracking and block-end divisor selection
   always_comb begin
      s_raw   = req_ch.sample_in;
      s_neg   = s_raw[SB-1];
      s_mag   = s_neg ? (SB'(0) - s_raw) : s_raw;
      pos_new = (!s_neg && (s_raw[SB-2:0] > pos_ff)) ? s_raw[SB-2:0] : pos_ff;
      neg_new = (s_neg && (s_mag > neg_ff)) ? s_mag : neg_ff;
      pos_big = {1'b0, pos_new} > neg_new;
      hi      = pos_big ? {1'b0, pos_new} : neg_new;
      lo      = pos_big ? neg_new : {1'b0, pos_new};
      lo_f    = (lo < EPS_Q) ? EPS_Q : lo;
      div_dividend = RW'(hi) << 12;
   end

   // ratio, target gating and process-path helpers
   always_comb begin
      if (div_stat.quot[15]) begin
         ratio = pasc_pkg::RATIO_SAT;
      end else if (div_stat.quot[14:0] > pasc_pkg::RATIO_SAT) begin
         ratio = pasc_pkg::RATIO_SAT;
      end else begin
         ratio = div_stat.quot[14:0];
      end
      gate    = (ratio > 15'(thresh_ff)) && (ratio > pasc_pkg::RATIO_ONE);
      d       = gate ? 14'(ratio - pasc_pkg::RATIO_ONE) : '0;
      str_c   = (strength_ff > pasc_pkg::UNITY16) ? pasc_pkg::UNITY16 : strength_ff;
      prod_hi = prod[32:16];
      pdiff   = (SB+4)'(mag_ff) * (SB+4)'(10) - NINE_ONE;
      pscaled = {pdiff, 16'b0} >> FRAC;
      blend_sum = 34'(hold_ff) + prod[33:0] + 34'd32768;
      rounded = prod + PW'(32768);
      m_raw   = rounded[SB+16:16];
      if (sneg_ff) begin
         m_c = (m_raw > HALF_Q + (SB+1)'(1)) ? HALF_Q + (SB+1)'(1) : m_raw;
      end else begin
         m_c = (m_raw > HALF_Q) ? HALF_Q : m_raw;
      end
      m_neg = (SB+1)'(0) - m_c;
   end

   // shared multiplier operand selection
   always_comb begin
      mul_en = 1'b1;
      mul_a  = '0;
      mul_b  = '0;
      unique case (state_ff)
         ST_TGT: begin
            mul_a = MA'({d, 2'b00});
            mul_b = pasc_pkg::RECIP5;
         end
         ST_FC: begin
            mul_a = MA'(factor_ff);
            mul_b = pasc_pkg::MUL_B_W'(coeff_ff);
         end
         ST_TC: begin
            mul_a = MA'(target_ff);
            mul_b = pasc_pkg::MUL_B_W'(18'd65536 - pasc_pkg::MUL_B_W'(coeff_ff));
         end
         ST_P2: begin
            mul_a = MA'(p_ff);
            mul_b = pasc_pkg::MUL_B_W'(p_ff);
         end
         ST_CURVE: begin
            mul_a = MA'(prod_hi);
            mul_b = pasc_pkg::THREE_UNITY - pasc_pkg::MUL_B_W'({p_ff, 1'b0});
         end
         ST_CORR: begin
            mul_a = MA'(prod_hi);
            mul_b = pasc_pkg::MUL_B_W'(factor_ff);
         end
         ST_GAIN: begin
            mul_a = MA'(prod_hi);
            mul_b = pasc_pkg::MUL_B_W'(str_c);
         end
         ST_SCALE: begin
            mul_a = MA'(mag_ff);
            mul_b = pasc_pkg::MUL_B_W'(pasc_pkg::UNITY16 - prod_hi);
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      enable_in     = enable_ff;
      strength_in   = strength_ff;
      thresh_in     = thresh_ff;
      coeff_in      = coeff_ff;
      pos_in        = pos_ff;
      neg_in        = neg_ff;
      factor_in     = factor_ff;
      rsp_valid_in  = rsp_valid_ff;
      res_in        = res_ff;
      mag_in        = mag_ff;
      sneg_in       = sneg_ff;
      p_in          = p_ff;
      target_in     = target_ff;
      hold_in       = hold_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_factor_in = rsp_factor_ff;
      div_ctrl      = '0;

      if (csr_we) begin
         unique case (csr_index)
            pasc_pkg::CSR_ENABLE:    enable_in   = csr_wdata[0];
            pasc_pkg::CSR_STRENGTH:  strength_in = csr_wdata;
            pasc_pkg::CSR_THRESHOLD: thresh_in   = csr_wdata[pasc_pkg::THRESH_W-1:0];
            pasc_pkg::CSR_SMOOTH:    coeff_in    = csr_wdata[pasc_pkg::COEFF_W-1:0];
         endcase
      end

      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_in   = s_raw;
               mag_in   = s_mag;
               sneg_in  = s_neg;
               state_in = ST_DONE;
               unique case (req_ch.mode)
                  pasc_pkg::MODE_ANALYZE, pasc_pkg::MODE_BLOCK_END: begin
                     if (!enable_ff) begin
                        factor_in = '0;
                        pos_in    = '0;
                        neg_in    = '0;
                     end else if (req_ch.mode == pasc_pkg::MODE_ANALYZE) begin
                        pos_in = pos_new;
                        neg_in = neg_new;
                     end else begin
                        pos_in = '0;
                        neg_in = '0;
                        if (hi < EPS_Q) begin
                           factor_in = '0;
                        end else begin
                           div_ctrl.load = 1'b1;
                           state_in      = ST_DIV;
                        end
                     end
                  end
                  pasc_pkg::MODE_PROCESS: begin
                     if (enable_ff && (factor_ff >= pasc_pkg::FACTOR_MIN) &&
                         (s_mag >= KNEE_Q)) begin
                        state_in = ST_PCALC;
                     end
                  end
                  pasc_pkg::MODE_UNUSED: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_DIV: begin
            div_ctrl.step = 1'b1;
            if (div_stat.last) begin
               state_in = ST_TGT;
            end
         end
         ST_TGT: begin
            state_in = ST_FC;
         end
         ST_FC: begin
            if (!gate) begin
               target_in = '0;
            end else if (d >= pasc_pkg::TARGET_KNEE) begin
               target_in = pasc_pkg::UNITY16;
            end else begin
               target_in = 17'(17'(d) * 17'd12 + 17'(prod[PW-1:17]));
            end
            state_in = ST_TC;
         end
         ST_TC: begin
            hold_in  = prod[32:0];
            state_in = ST_BLEND;
         end
         ST_BLEND: begin
            factor_in = blend_sum[32:16];
            state_in  = ST_DONE;
         end
         ST_PCALC: begin
            p_in     = (pscaled > (SB+20)'(65536)) ? pasc_pkg::UNITY16 : pscaled[16:0];
            state_in = ST_P2;
         end
         ST_P2:    state_in = ST_CURVE;
         ST_CURVE: state_in = ST_CORR;
         ST_CORR:  state_in = ST_GAIN;
         ST_GAIN:  state_in = ST_SCALE;
         ST_SCALE: state_in = ST_ROUND;
         ST_ROUND: begin
            res_in   = sneg_ff ? m_neg[SB-1:0] : m_c[SB-1:0];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = res_ff;
               rsp_factor_in = factor_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         enable_ff    <= pasc_pkg::ENABLE_RESET;
         strength_ff  <= pasc_pkg::STRENGTH_RESET;
         thresh_ff    <= pasc_pkg::THRESHOLD_RESET;
         coeff_ff     <= pasc_pkg::SMOOTH_RESET;
         pos_ff       <= '0;
         neg_ff       <= '0;
         factor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         enable_ff    <= enable_in;
         strength_ff  <= strength_in;
         thresh_ff    <= thresh_in;
         coeff_ff     <= coeff_in;
         pos_ff       <= pos_in;
         neg_ff       <= neg_in;
         factor_ff    <= factor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff        <= res_in;
      mag_ff        <= mag_in;
      sneg_ff       <= sneg_in;
      p_ff          <= p_in;
      target_ff     <= target_in;
      hold_ff       <= hold_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_factor_ff <= rsp_factor_in;
   end

endmodule
